// ===== hw/rtl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package sem_pkg;

	localparam int PIX_W         = 8;
	localparam int FW_W          = 12;
	localparam int FH_W          = 13;
	localparam int ROW_W         = 12;
	localparam int GRAD_W        = 11;
	localparam int MIN_DIM       = 3;
	localparam int MAX_HEIGHT    = 4096;
	localparam int EDGE_MAX      = 255;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int APB_AW        = 3;
	localparam int APB_DW        = 32;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Per-word control travelling with a pixel from the counters to the window
	typedef struct packed {
		logic emit;
		logic last;
	} s1_ctrl_t;

endpackage

// ===== hw/rtl/sem_cfg.sv =====
// APB register file for frame width and height, plus the clamped values in use.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_cfg #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
	parameter int CLW       = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sem_pkg::APB_AW-1:0]  paddr,
	input  logic [sem_pkg::APB_DW-1:0]  pwdata,
	output logic [sem_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [CLW-1:0]              width_use,
	output logic [sem_pkg::FH_W-1:0]    height_use
);

	logic [sem_pkg::FW_W-1:0] frame_width_q;
	logic [sem_pkg::FH_W-1:0] frame_height_q;
	logic                     wr_en;
	sem_pkg::reg_idx_t        reg_idx;
	logic [CLW-1:0]           width_ext;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = sem_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sem_pkg::FW_W'(sem_pkg::WIDTH_RESET);
			frame_height_q <= sem_pkg::FH_W'(sem_pkg::HEIGHT_RESET);
		end else if (wr_en) begin
			case (reg_idx)
				sem_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[sem_pkg::FW_W-1:0];
				sem_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[sem_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sem_pkg::REG_FRAME_WIDTH:  prdata = sem_pkg::APB_DW'(frame_width_q);
			sem_pkg::REG_FRAME_HEIGHT: prdata = sem_pkg::APB_DW'(frame_height_q);
			default:                   prdata = '0;
		endcase
	end

	// Clamp the written values into the supported range
	assign width_ext = CLW'(frame_width_q);

	always_comb begin
		if (width_ext < CLW'(sem_pkg::MIN_DIM))
			width_use = CLW'(sem_pkg::MIN_DIM);
		else if (width_ext > CLW'(MAX_WIDTH))
			width_use = CLW'(MAX_WIDTH);
		else
			width_use = width_ext;
	end

	always_comb begin
		if (frame_height_q < sem_pkg::FH_W'(sem_pkg::MIN_DIM))
			height_use = sem_pkg::FH_W'(sem_pkg::MIN_DIM);
		else if (frame_height_q > sem_pkg::FH_W'(sem_pkg::MAX_HEIGHT))
			height_use = sem_pkg::FH_W'(sem_pkg::MAX_HEIGHT);
		else
			height_use = frame_height_q;
	end

endmodule

// ===== hw/rtl/sem_line_store.sv =====
// Two-row line store: one synchronous memory, {two rows up, one row up} per column.
// Read at accept, read-modify-write when the accepted word retires into the window. Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_line_store #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
	parameter int AW        = 11
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [sem_pkg::PIX_W-1:0]    wr_pix,
	output logic [2*sem_pkg::PIX_W-1:0]  rd_data
);

	logic [2*sem_pkg::PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*sem_pkg::PIX_W-1:0] rd_data_q;

	// A column comes back at least three words later, so the write of one
	// word never meets the read of the next at the same entry.
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
		if (wr_en)
			mem[wr_addr] <= {rd_data_q[sem_pkg::PIX_W-1:0], wr_pix};
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/sem_window.sv =====
// 3x3 window, Sobel gradients, L1 magnitude with saturation and output register.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2*sem_pkg::PIX_W-1:0]  above,
	input  logic [sem_pkg::PIX_W-1:0]    pix,
	input  sem_pkg::s1_ctrl_t            ctrl,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sem_pkg::PIX_W-1:0]    edge_value,
	output logic                         last_of_frame
);

	localparam int GW = sem_pkg::GRAD_W;
	localparam int PW = sem_pkg::PIX_W;

	logic [PW-1:0]        win_q [9];
	logic [PW-1:0]        win_d [9];
	logic                 retire;
	logic                 en2;
	logic                 o_free;
	logic                 v2_q;
	logic signed [GW-1:0] gv_d, gh_d;
	logic signed [GW-1:0] gv_s2, gh_s2;
	logic                 last_s2;
	logic [GW-2:0]        abs_gv, abs_gh;
	logic [GW-1:0]        mag;
	logic                 out_valid_q;
	logic [PW-1:0]        edge_q;
	logic                 last_q;

	assign o_free   = !out_valid_q || out_ready;
	assign en2      = !v2_q || o_free;
	// A non-emitting word only updates the window and may always retire
	assign in_ready = !ctrl.emit || en2;
	assign retire   = in_valid && in_ready;

	// Shift the window one column left, newest column from the line store and the incoming pixel
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r*3+0] = win_q[r*3+1];
			win_d[r*3+1] = win_q[r*3+2];
		end
		win_d[2] = above[2*PW-1:PW];
		win_d[5] = above[PW-1:0];
		win_d[8] = pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (retire) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= win_d[i];
		end
	end

	always_comb begin
		gv_d = (GW'(win_d[0]) - GW'(win_d[6]))
		     + ((GW'(win_d[1]) - GW'(win_d[7])) <<< 1)
		     + (GW'(win_d[2]) - GW'(win_d[8]));
		gh_d = (GW'(win_d[0]) - GW'(win_d[2]))
		     + ((GW'(win_d[3]) - GW'(win_d[5])) <<< 1)
		     + (GW'(win_d[6]) - GW'(win_d[8]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v2_q <= 1'b0;
		else if (en2)
			v2_q <= retire && ctrl.emit;
	end

	always_ff @(posedge clk) begin
		if (en2 && retire && ctrl.emit) begin
			gv_s2   <= gv_d;
			gh_s2   <= gh_d;
			last_s2 <= ctrl.last;
		end
	end

	assign abs_gv = gv_s2[GW-1] ? (GW-1)'(-gv_s2) : gv_s2[GW-2:0];
	assign abs_gh = gh_s2[GW-1] ? (GW-1)'(-gh_s2) : gh_s2[GW-2:0];
	assign mag    = GW'(abs_gv) + GW'(abs_gh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (o_free)
			out_valid_q <= v2_q;
	end

	always_ff @(posedge clk) begin
		if (o_free && v2_q) begin
			edge_q <= (mag > GW'(sem_pkg::EDGE_MAX)) ? PW'(sem_pkg::EDGE_MAX) : mag[PW-1:0];
			last_q <= last_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign edge_value    = edge_q;
	assign last_of_frame = last_q;

endmodule

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// Sobel 3x3 edge magnitude, streaming. A pixel that completes a window is registered
// with the line store read at the edge that accepts it, then passes the gradient and
// magnitude registers. Throughput: one pixel per clock while m_tready does not stall
// the output, set by the line store taking one read and one write-back per cycle.
// Reset clears counters, window, pipeline valids and loads width 640 / height 480;
// the line store is not cleared.
`timescale 1ns / 1ps

module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] pixel_value
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] edge_value
	output logic                        m_tlast,   // last_of_frame
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sem_pkg::APB_AW-1:0]  paddr,
	input  logic [sem_pkg::APB_DW-1:0]  pwdata,
	output logic [sem_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CLW = ($clog2(MAX_WIDTH + 1) > sem_pkg::FW_W) ?
	                     $clog2(MAX_WIDTH + 1) : sem_pkg::FW_W;
	localparam int RW  = sem_pkg::ROW_W;
	localparam int HW  = sem_pkg::FH_W;

	logic [CLW-1:0]              width_use;
	logic [HW-1:0]               height_use;
	logic [AW-1:0]               col_q, c_pre, col_d;
	logic [RW-1:0]               row_q, r_pre, row_d;
	logic                        col_wrap, c_end;
	logic [HW-1:0]               r_a, r_b;
	logic [CLW-1:0]              c_inc;
	logic                        accept;
	logic                        ready_s1;
	logic                        v1_q;
	logic [sem_pkg::PIX_W-1:0]   pix_s1;
	logic [AW-1:0]               col_s1;
	sem_pkg::s1_ctrl_t           ctrl_d, ctrl_s1;
	logic [2*sem_pkg::PIX_W-1:0] above;

	sem_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.CLW       (CLW)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.width_use  (width_use),
		.height_use (height_use)
	);

	assign s_tready = !v1_q || ready_s1;
	assign accept   = s_tvalid && s_tready;

	// Position of this pixel: wrap first if the bounds shrank under the counters
	always_comb begin
		col_wrap = CLW'(col_q) >= width_use;
		c_pre    = col_wrap ? '0 : col_q;
		r_a      = HW'(row_q) + HW'(col_wrap);
		r_pre    = (r_a >= height_use) ? '0 : r_a[RW-1:0];

		c_inc = CLW'(c_pre) + CLW'(1);
		c_end = c_inc >= width_use;
		r_b   = HW'(r_pre) + HW'(1);
		col_d = c_end ? '0 : c_inc[AW-1:0];
		if (c_end)
			row_d = (r_b >= height_use) ? '0 : r_b[RW-1:0];
		else
			row_d = r_pre;

		ctrl_d.emit = (r_pre >= RW'(2)) && (CLW'(c_pre) >= CLW'(2));
		ctrl_d.last = (HW'(r_pre) == height_use - HW'(1)) &&
		              (CLW'(c_pre) == width_use - CLW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v1_q  <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			v1_q <= accept || (v1_q && !ready_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= s_tdata;
			col_s1  <= c_pre;
			ctrl_s1 <= ctrl_d;
		end
	end

	sem_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c_pre),
		.wr_en   (v1_q && ready_s1),
		.wr_addr (col_s1),
		.wr_pix  (pix_s1),
		.rd_data (above)
	);

	sem_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v1_q),
		.in_ready      (ready_s1),
		.above         (above),
		.pix           (pix_s1),
		.ctrl          (ctrl_s1),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.edge_value    (m_tdata),
		.last_of_frame (m_tlast)
	);

endmodule

// ===== hw/rtl/sem_port_checker.sv =====
// Port-level checks for sobel_edge_magnitude, attached by bind.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_port_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tready,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sem_pkg::APB_AW-1:0]  paddr,
	input  logic [sem_pkg::APB_DW-1:0]  pwdata,
	input  logic [sem_pkg::APB_DW-1:0]  prdata
);

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// With the output side draining, the input side never stalls
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled while output side is free");

	// A width write reads back in the next cycle
	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == 1'b0 |=>
		paddr[2] != 1'b0 || prdata[11:0] == $past(pwdata[11:0]))
		else $error("frame width readback mismatch");

endmodule

bind sobel_edge_magnitude sem_port_checker u_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);

// ===== tb/sobel_tb_pkg.sv =====
// Edge-magnitude tracker for the Sobel testbench: mirrors the line store, window and
// counters, and queues the edge words the block owes. Depends on sem_pkg.
`timescale 1ns / 1ps

package sobel_tb_pkg;
	import sem_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] magnitude;
		logic             last;
	} edge_word_t;

	class sobel_tracker;
		logic [FW_W-1:0]  width_reg;
		logic [FH_W-1:0]  height_reg;
		logic [15:0]      line_mem [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] win [9];
		int               row;
		int               col;
		int               cols_written;
		int               errors;
		edge_word_t       pending [$];

		function new();
			width_reg    = FW_W'(WIDTH_RESET);
			height_reg   = FH_W'(HEIGHT_RESET);
			row          = 0;
			col          = 0;
			cols_written = 0;
			errors       = 0;
			foreach (line_mem[i]) line_mem[i] = '0;
			foreach (win[i]) win[i] = '0;
		endfunction

		function int eff_width();
			if (width_reg < MIN_DIM) return MIN_DIM;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg < MIN_DIM) return MIN_DIM;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return int'(height_reg);
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
			case (idx)
				REG_FRAME_WIDTH: begin
					width_reg = value[FW_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_reg = value[FH_W-1:0];
				end
				default: ;
			endcase
		endfunction

		function bit at_frame_start();
			return row == 0 && col == 0;
		endfunction

		// Pixels left until the current frame closes, counting a pending wrap
		function int to_frame_end();
			int w, h, r, c;
			w = eff_width();
			h = eff_height();
			r = row;
			c = col;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) r = 0;
			return (h - r) * w - c;
		endfunction

		function void take_pixel(logic [PIX_W-1:0] pix);
			int w, h, gv, gh, mag;
			logic [15:0] above;
			edge_word_t word;
			w = eff_width();
			h = eff_height();
			// counters may sit past a bound that shrank between words
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h) row = 0;

			above = line_mem[col];
			win[0] = win[1];
			win[1] = win[2];
			win[3] = win[4];
			win[4] = win[5];
			win[6] = win[7];
			win[7] = win[8];
			win[2] = above[15:8];
			win[5] = above[7:0];
			win[8] = pix;
			line_mem[col] = {above[7:0], pix};
			if (col + 1 > cols_written) cols_written = col + 1;

			if (row >= 2 && col >= 2) begin
				gv = (int'(win[0]) - int'(win[6])) + 2 * (int'(win[1]) - int'(win[7]))
					+ (int'(win[2]) - int'(win[8]));
				gh = (int'(win[0]) - int'(win[2])) + 2 * (int'(win[3]) - int'(win[5]))
					+ (int'(win[6]) - int'(win[8]));
				if (gv < 0) gv = -gv;
				if (gh < 0) gh = -gh;
				mag = gv + gh;
				if (mag > EDGE_MAX) mag = EDGE_MAX;
				word.magnitude = mag[PIX_W-1:0];
				word.last      = (row == h - 1 && col == w - 1);
				pending.push_back(word);
			end

			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
		endfunction

		function void match_edge(logic [PIX_W-1:0] magnitude, logic last);
			edge_word_t word;
			if (pending.size() == 0) begin
				$error("edge_value: no word expected, actual %0d (last_of_frame %0b)",
					magnitude, last);
				errors++;
				return;
			end
			word = pending.pop_front();
			if (magnitude !== word.magnitude) begin
				$error("edge_value: expected %0d, actual %0d", word.magnitude, magnitude);
				errors++;
			end
			if (last !== word.last) begin
				$error("last_of_frame: expected %0b, actual %0b", word.last, last);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for sobel_edge_magnitude: drives pixel frames and APB
// register writes, checks every edge word. Depends on sem_pkg and sobel_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
	import sem_pkg::*;
	import sobel_tb_pkg::*;

	localparam int PIXEL_TARGET = 1050;
	localparam int WIDE_COUNT   = 150;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;

	typedef enum int {
		PIX_NOISE,
		PIX_FLAT,
		PIX_BINARY
	} pix_mode_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] pixel_value
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;   // [7:0] edge_value
	logic              m_tlast;   // last_of_frame
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sobel_tracker tracker = new();
	bit           quiet;
	bit           hold_request;
	bit           sender_gaps;
	logic [7:0]   directed_pix [27] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
		8'd10,  8'd20,  8'd30,  8'd10,  8'd20,  8'd30,  8'd10,  8'd20,  8'd30,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};

	sobel_edge_magnitude dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.match_edge(m_tdata, m_tlast);
	end

	task automatic reg_verify(input reg_idx_t idx, input logic [APB_DW-1:0] exp_val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_AW'(4 * int'(idx));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== exp_val) begin
			$error("%s: expected %0d, actual %0d", idx.name(), exp_val, prdata);
			tracker.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Upper pwdata bits get noise; the register keeps only its own width
	task automatic reg_write(input reg_idx_t idx, input int value);
		logic [APB_DW-1:0] mask, data;
		mask = (idx == REG_FRAME_WIDTH) ? (32'd1 << FW_W) - 32'd1 : (32'd1 << FH_W) - 32'd1;
		data = ($urandom() & ~mask) | (APB_DW'(value) & mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * int'(idx));
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		reg_verify(idx, data & mask);
	endtask

	task automatic send_pixel(input logic [7:0] pix);
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		tracker.take_pixel(pix);
		if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Hold off until every owed word is out, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int count, input pix_mode_t mode);
		logic [7:0] base, pix;
		base = 8'($urandom_range(0, 240));
		for (int n = 0; n < count; n++) begin
			case (mode)
				PIX_NOISE: begin
					pix = 8'($urandom);
				end
				PIX_FLAT: begin
					pix = base + 8'($urandom_range(0, 15));
				end
				default: begin
					pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
			endcase
			send_pixel(pix);
		end
		drain();
	endtask

	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	initial begin
		int wv, hv, w_eff, h_eff, count, r, random_sent;
		random_sent = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_verify(REG_FRAME_WIDTH, WIDTH_RESET);
		reg_verify(REG_FRAME_HEIGHT, HEIGHT_RESET);

		// smallest frame, sizes below range: saturating, mid and flat edges
		sender_gaps = 1'b1;
		reg_write(REG_FRAME_WIDTH, 0);
		reg_write(REG_FRAME_HEIGHT, 2);
		foreach (directed_pix[i]) send_pixel(directed_pix[i]);
		drain();

		// back-pressure: output held while input keeps coming
		reg_write(REG_FRAME_WIDTH, 5);
		reg_write(REG_FRAME_HEIGHT, 6);
		sender_gaps  = 1'b0;
		hold_request = 1'b1;
		run_phase(120, PIX_NOISE);

		// width register all ones clamps to the widest row: no wrap within the first row
		sender_gaps = 1'b1;
		reg_write(REG_FRAME_WIDTH, (1 << FW_W) - 1);
		reg_write(REG_FRAME_HEIGHT, MIN_DIM);
		run_phase(WIDE_COUNT, PIX_FLAT);

		while (random_sent < PIXEL_TARGET) begin
			if (random_sent > PIXEL_TARGET * 4 / 5) quiet = 1'b1;
			sender_gaps = ($urandom_range(0, 3) != 0);

			r = $urandom_range(0, 9);
			if (r == 0) wv = $urandom_range(0, MIN_DIM - 1);
			else if (r < 3) wv = $urandom_range(11, 48);
			else wv = $urandom_range(MIN_DIM, 10);
			// mid-frame, the width may only cover columns already stored
			if (!tracker.at_frame_start() && wv > tracker.cols_written)
				wv = tracker.cols_written;

			r = $urandom_range(0, 9);
			if (r == 0) hv = $urandom_range(0, MIN_DIM - 1);
			else if (r == 1) hv = $urandom_range(MAX_HEIGHT, (1 << FH_W) - 1);
			else hv = $urandom_range(MIN_DIM, 8);

			reg_write(REG_FRAME_WIDTH, wv);
			reg_write(REG_FRAME_HEIGHT, hv);
			w_eff = tracker.eff_width();
			h_eff = tracker.eff_height();

			if (h_eff > 64) count = $urandom_range(1, 6 * w_eff);
			else if ($urandom_range(0, 1)) count = tracker.to_frame_end()
				+ w_eff * h_eff * $urandom_range(0, 2);
			else count = $urandom_range(1, 2 * w_eff * h_eff);
			if (count > PIXEL_TARGET - random_sent) count = PIXEL_TARGET - random_sent;

			run_phase(count, pix_mode_t'($urandom_range(0, 2)));
			random_sent += count;
		end

		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("** sobel_edge_magnitude: PASSED **");
		end else begin
			$display("** sobel_edge_magnitude: FAILED **");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("** sobel_edge_magnitude: FAILED **");
		$finish;
	end

endmodule

// ===== sobel_edge_magnitude.f =====
hw/rtl/sem_pkg.sv
hw/rtl/sem_cfg.sv
hw/rtl/sem_line_store.sv
hw/rtl/sem_window.sv
hw/rtl/sobel_edge_magnitude.sv
hw/rtl/sem_port_checker.sv
tb/sobel_tb_pkg.sv
tb/tb_top.sv
